// ----- src/mtep_pkg.sv -----
package mtep_pkg;

  // Largest number of bytes in one delta time.
  localparam int unsigned MAX_DELTA_BYTES = 4;

  localparam logic [7:0] META_MARK = 8'hFF;

  typedef logic [2:0] phase_t;
  typedef logic [2:0] kind_t;

  // Parse phases.
  localparam phase_t PH_DELTA  = 3'd0;
  localparam phase_t PH_STATUS = 3'd1;
  localparam phase_t PH_MTYPE  = 3'd2;
  localparam phase_t PH_MLEN   = 3'd3;
  localparam phase_t PH_MDATA  = 3'd4;
  localparam phase_t PH_CD1    = 3'd5;
  localparam phase_t PH_CD2    = 3'd6;
  localparam phase_t PH_ENDED  = 3'd7;

  // Event kinds. A meta type that is skipped maps to KIND_SKIP, which shares
  // its code with channel messages but is never emitted.
  localparam kind_t KIND_CHAN  = 3'd0;
  localparam kind_t KIND_SKIP  = 3'd0;
  localparam kind_t KIND_TEMPO = 3'd1;
  localparam kind_t KIND_TSIG  = 3'd2;
  localparam kind_t KIND_KSIG  = 3'd3;
  localparam kind_t KIND_SMPTE = 3'd4;
  localparam kind_t KIND_END   = 3'd5;

  // Meta event types.
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG  = 8'h58;
  localparam logic [7:0] META_KSIG  = 8'h59;
  localparam logic [7:0] META_SMPTE = 8'h54;
  localparam logic [7:0] META_END   = 8'h2F;

  // Channel status high nibbles.
  localparam logic [3:0] HI_CHAN_LO = 4'h8;
  localparam logic [3:0] HI_CHAN_HI = 4'hE;
  localparam logic [3:0] HI_PROG    = 4'hC;
  localparam logic [3:0] HI_CHPRESS = 4'hD;

  function automatic kind_t meta_kind(input logic [7:0] t);
    kind_t k;
    case (t)
      META_TEMPO: k = KIND_TEMPO;
      META_TSIG:  k = KIND_TSIG;
      META_KSIG:  k = KIND_KSIG;
      META_SMPTE: k = KIND_SMPTE;
      META_END:   k = KIND_END;
      default:    k = KIND_SKIP;
    endcase
    return k;
  endfunction

endpackage

// ----- src/mtep_if.sv -----
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic       track_start;
  logic [7:0] data_byte;

  modport source (output valid, output track_start, output data_byte, input ready);
  modport sink   (input valid, input track_start, input data_byte, output ready);
endinterface

interface mtep_out_if;
  logic                 valid;
  logic                 ready;
  mtep_pkg::kind_t      event_kind;
  logic [39:0]          event_value;
  logic [27:0]          delta_time;

  modport source (output valid, output event_kind, output event_value, output delta_time,
                  input ready);
  modport sink   (input valid, input event_kind, input event_value, input delta_time,
                  output ready);
endinterface

// ----- src/midi_track_event_parser_top.sv -----
// Track event parser for standard MIDI files.
// The input channel carries one byte of a track's event stream per item, plus
// a track_start flag that marks the first delta byte of a new track and forces
// the parser back to reading a delta time. The output channel carries one
// decoded event per item: its kind, a packed 40-bit value and the decoded
// delta time that preceded it. Channel messages, tempo, time signature, key
// signature, SMPTE offset and end of track are reported; other bytes and
// unknown meta events produce no output item.
// An input item is captured in the input register when it is accepted, and the
// parse step then loads the result register from it. Throughput is one byte per
// cycle while the receiver does not stall, set by the single parse step between
// the input register and the result register.
// When the receiver stalls, the result register holds its item and the input
// register holds one more byte; after that the input channel drops ready.
// Reset (synchronous, active low) empties both registers and returns the
// parser to expecting a delta time with all state cleared.
module midi_track_event_parser_top (
  input logic             clk,
  input logic             rst_n,
  mtep_in_if.sink         in_if,
  mtep_out_if.source      out_if
);

  // Input register.
  logic       in_vld_r;
  logic       in_ts_r;
  logic [7:0] in_byte_r;

  // Parser state.
  mtep_pkg::phase_t phase_r, phase_nxt;
  logic [27:0]      dacc_r, dacc_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       mtype_r, mtype_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [39:0]      pay_r, pay_nxt;

  // Result register.
  logic             out_vld_r;
  mtep_pkg::kind_t  out_kind_r;
  logic [39:0]      out_value_r;
  logic [27:0]      out_delta_r;

  logic             advance;
  logic             in_accept;
  logic             emit;
  mtep_pkg::kind_t  emit_kind;

  // Step comb scratch.
  mtep_pkg::phase_t ph;
  logic [7:0]       cnt;
  logic [7:0]       cnt_inc;
  logic [7:0]       cnt_dec;
  logic [27:0]      dacc_base;
  mtep_pkg::kind_t  mk;
  logic             finish;

  // The parse step runs when a byte waits and the result register is free or
  // being emptied in this same cycle.
  assign advance   = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;
  assign in_accept = in_if.valid && in_if.ready;

  always_comb begin
    // A new track restarts the parser in the delta phase.
    ph        = in_ts_r ? mtep_pkg::PH_DELTA : phase_r;
    cnt       = in_ts_r ? 8'd0 : cnt_r;
    cnt_inc   = cnt + 8'd1;
    cnt_dec   = (cnt != 8'd0) ? cnt - 8'd1 : 8'd0;
    dacc_base = (cnt == 8'd0) ? 28'd0 : dacc_r;
    mk        = mtep_pkg::meta_kind(mtype_r);

    phase_nxt  = ph;
    cnt_nxt    = cnt;
    dacc_nxt   = dacc_r;
    status_nxt = status_r;
    mtype_nxt  = mtype_r;
    pay_nxt    = pay_r;
    emit       = 1'b0;
    emit_kind  = mtep_pkg::KIND_CHAN;
    finish     = 1'b0;

    case (ph)
      mtep_pkg::PH_DELTA: begin
        // Seven bits per byte, most significant group first.
        dacc_nxt = {dacc_base[20:0], in_byte_r[6:0]};
        if (!in_byte_r[7] || (cnt_inc >= 8'(mtep_pkg::MAX_DELTA_BYTES))) begin
          phase_nxt = mtep_pkg::PH_STATUS;
          cnt_nxt   = 8'd0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (in_byte_r == mtep_pkg::META_MARK) begin
          phase_nxt = mtep_pkg::PH_MTYPE;
        end else if (in_byte_r[7:4] inside {[mtep_pkg::HI_CHAN_LO:mtep_pkg::HI_CHAN_HI]}) begin
          status_nxt = in_byte_r;
          pay_nxt    = {32'd0, in_byte_r};
          phase_nxt  = mtep_pkg::PH_CD1;
        end else begin
          // System and stray bytes are dropped.
          phase_nxt = mtep_pkg::PH_DELTA;
          cnt_nxt   = 8'd0;
        end
      end
      mtep_pkg::PH_MTYPE: begin
        mtype_nxt = in_byte_r;
        phase_nxt = mtep_pkg::PH_MLEN;
      end
      mtep_pkg::PH_MLEN: begin
        pay_nxt = 40'd0;
        cnt_nxt = in_byte_r;
        if (in_byte_r == 8'd0) begin
          finish = 1'b1;
        end else begin
          phase_nxt = mtep_pkg::PH_MDATA;
        end
      end
      mtep_pkg::PH_MDATA: begin
        // Only the last five data bytes survive the shift.
        pay_nxt = {pay_r[31:0], in_byte_r};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 8'd0) begin
          finish = 1'b1;
        end
      end
      mtep_pkg::PH_CD1: begin
        pay_nxt = {24'd0, in_byte_r, status_r};
        if ((status_r[7:4] == mtep_pkg::HI_PROG) || (status_r[7:4] == mtep_pkg::HI_CHPRESS)) begin
          phase_nxt = mtep_pkg::PH_DELTA;
          cnt_nxt   = 8'd0;
          emit      = 1'b1;
        end else begin
          phase_nxt = mtep_pkg::PH_CD2;
        end
      end
      mtep_pkg::PH_CD2: begin
        pay_nxt   = {16'd0, in_byte_r, pay_r[15:0]};
        phase_nxt = mtep_pkg::PH_DELTA;
        cnt_nxt   = 8'd0;
        emit      = 1'b1;
      end
      default: begin
        // After end of track every byte is ignored until a new track starts.
      end
    endcase

    // Close of a meta event: end of track parks the parser, anything else
    // goes back to the delta phase; only captured types emit.
    if (finish) begin
      cnt_nxt   = 8'd0;
      phase_nxt = (mk == mtep_pkg::KIND_END) ? mtep_pkg::PH_ENDED : mtep_pkg::PH_DELTA;
      if (mk != mtep_pkg::KIND_SKIP) begin
        emit      = 1'b1;
        emit_kind = mk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_ts_r   <= in_if.track_start;
      in_byte_r <= in_if.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mtep_pkg::PH_DELTA;
      cnt_r    <= 8'd0;
      dacc_r   <= 28'd0;
      status_r <= 8'd0;
      mtype_r  <= 8'd0;
      pay_r    <= 40'd0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      dacc_r   <= dacc_nxt;
      status_r <= status_nxt;
      mtype_r  <= mtype_nxt;
      pay_r    <= pay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= emit;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind_r  <= emit_kind;
      out_value_r <= pay_nxt;
      out_delta_r <= dacc_nxt;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.event_kind  = out_kind_r;
  assign out_if.event_value = out_value_r;
  assign out_if.delta_time  = out_delta_r;

  // A waiting byte that cannot be parsed stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r)
    else $error("input byte lost while the result register was blocked");

  // A new result only appears through a parse step.
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(advance))
    else $error("result appeared without a parse step");

  // Reporting end of track leaves the parser parked.
  a_end_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && (emit_kind == mtep_pkg::KIND_END)) |=> (phase_r == mtep_pkg::PH_ENDED))
    else $error("end of track did not park the parser");

endmodule
